/* rtl/assert_macros.svh */
// assertion macros used by the buffer manager core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define TBM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define TBM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tbm_pkg.sv */
// types and constants of the triple buffer manager
package tbm_pkg;

   localparam int NUM_BUFFERS = 3;
   localparam int BUF_IDX_W   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int OPCODE_W    = 3;
   localparam int INDEX_W     = 3;
   localparam int CNT_W       = INDEX_W + 1;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ACQUIRE = 3'd0,
      OP_PUBLISH = 3'd1,
      OP_ABANDON = 3'd2,
      OP_TAKE    = 3'd3,
      OP_RELEASE = 3'd4,
      OP_QUERY   = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_FREE    = 2'd0,
      ST_WRITING = 2'd1,
      ST_READY   = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [INDEX_W-1:0] buf_num;
   } req_item_type;

   typedef struct packed {
      logic               index_valid;
      logic [INDEX_W-1:0] result_index;
      logic               pending_flag;
   } rsp_item_type;

endpackage

/* rtl/tbm_core.sv */
// buffer status registers and the single-pass operation logic
module tbm_core
   import tbm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type rsp
);

`include "assert_macros.svh"

   status_type            status_ff [NUM_BUFFERS];
   status_type            status_in [NUM_BUFFERS];
   logic                  pend_valid_ff;
   logic                  pend_valid_in;
   logic [BUF_IDX_W-1:0]  pend_slot_ff;
   logic [BUF_IDX_W-1:0]  pend_slot_in;

   logic                  idx_ok;
   logic [BUF_IDX_W-1:0]  idx;
   logic                  pend_ready;
   logic                  acq_found;
   logic [BUF_IDX_W-1:0]  acq_idx;
   logic                  got;
   logic [BUF_IDX_W-1:0]  res;

   assign idx_ok     = ({1'b0, item.buf_num} < CNT_W'(NUM_BUFFERS));
   assign idx        = item.buf_num[BUF_IDX_W-1:0];
   assign pend_ready = pend_valid_ff && (status_ff[pend_slot_ff] == ST_READY);

   // lowest free buffer
   always_comb begin
      acq_found = 1'b0;
      acq_idx   = '0;
      for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
         if (status_ff[i] == ST_FREE) begin
            acq_found = 1'b1;
            acq_idx   = BUF_IDX_W'(i);
         end
      end
   end

   always_comb begin
      status_in     = status_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      got           = 1'b0;
      res           = '0;
      unique case (item.opcode)
         OP_ACQUIRE: begin
            if (acq_found) begin
               status_in[acq_idx] = ST_WRITING;
               got                = 1'b1;
               res                = acq_idx;
            end
         end
         OP_PUBLISH: begin
            if (idx_ok) begin
               // an untaken earlier frame is dropped
               if (pend_ready) begin
                  status_in[pend_slot_ff] = ST_FREE;
               end
               status_in[idx] = ST_READY;
               pend_valid_in  = 1'b1;
               pend_slot_in   = idx;
            end
         end
         OP_ABANDON: begin
            if (idx_ok && status_ff[idx] == ST_WRITING) begin
               status_in[idx] = ST_FREE;
            end
         end
         OP_TAKE: begin
            if (pend_ready) begin
               got           = 1'b1;
               res           = pend_slot_ff;
               pend_valid_in = 1'b0;
            end
         end
         OP_RELEASE: begin
            if (idx_ok) begin
               status_in[idx] = ST_FREE;
            end
         end
         default: begin
         end
      endcase
      rsp.index_valid  = got;
      rsp.result_index = INDEX_W'(res);
      rsp.pending_flag = pend_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            status_ff[i] <= ST_FREE;
         end
         pend_valid_ff <= 1'b0;
         pend_slot_ff  <= '0;
      end else if (fire) begin
         status_ff     <= status_in;
         pend_valid_ff <= pend_valid_in;
         pend_slot_ff  <= pend_slot_in;
      end
   end

   `TBM_ASSERT_NOW(a_index_only_acq_take, rsp.index_valid, item.opcode == OP_ACQUIRE || item.opcode == OP_TAKE, "index returned by an operation that hands out none")
   `TBM_ASSERT_NEXT(a_take_clears_pending, fire && item.opcode == OP_TAKE && rsp.index_valid, !pend_valid_ff, "pending slot survived a successful take")
   `TBM_ASSERT_NEXT(a_acquire_marks_writing, fire && item.opcode == OP_ACQUIRE && acq_found, status_ff[$past(acq_idx)] == ST_WRITING, "acquired buffer not marked writing")
   `TBM_ASSERT_NEXT(a_publish_pends_ready, fire && item.opcode == OP_PUBLISH && idx_ok, pend_valid_ff && status_ff[pend_slot_ff] == ST_READY, "published buffer not pending and ready")

endmodule

/* rtl/tbm_rsp_reg.sv */
// result register in front of the result channel
module tbm_rsp_reg
   import tbm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type rsp_in,
   input  logic         out_ready,
   output logic         out_valid,
   output logic         can_load,
   output rsp_item_type rsp_out
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign can_load  = !valid_ff || out_ready;
   assign valid_in  = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   assign out_valid = valid_ff;
   assign rsp_out   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= rsp_in;
      end
   end

endmodule

/* rtl/triple_buffer_manager.sv */
// top level of the triple buffer manager
// Frame buffer manager for a small pool of stage buffers (free, writing or
// ready) plus one pending-ready slot. Each request item carries an opcode
// (acquire, publish, abandon, take, release, query) and a buffer number, and
// produces exactly one result item: whether a buffer number was handed out,
// that number, and whether a published frame is pending afterwards.
// Requests land in an input register; from there the whole operation reads
// and updates the buffer status registers in a single pass and the result is
// written into the result register. One item per clock is sustained while
// rsp_tready is high; the pace is set by the status register update, which
// completes for one item each cycle. Out-of-range buffer numbers are ignored,
// and opcodes 6 and 7 behave like query.
module triple_buffer_manager
   import tbm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // opcode[2:0], buf_num[5:3], upper bits ignored
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // result_index[2:0], pending_flag[3], zero pad
   output logic                   rsp_tuser   // index_valid
);

   // input register
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   req_item_type req_item;

   // handshake between the stages
   logic         req_accept;
   logic         fire;
   logic         can_load;

   rsp_item_type core_rsp;
   rsp_item_type out_rsp;

   assign req_item.opcode  = opcode_type'(req_tdata[OPCODE_W-1:0]);
   assign req_item.buf_num = req_tdata[OPCODE_W+INDEX_W-1:OPCODE_W];

   // the held item moves on whenever the result register has room
   assign fire        = in_valid_ff && can_load;
   assign req_tready  = !in_valid_ff || fire;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
   end

   // status registers and operation logic
   tbm_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_item_ff),
      .rsp   (core_rsp)
   );

   // result register
   tbm_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .rsp_in    (core_rsp),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .can_load  (can_load),
      .rsp_out   (out_rsp)
   );

   // pack the result item
   assign rsp_tuser = out_rsp.index_valid;
   assign rsp_tdata = {{(RSP_TDATA_W - INDEX_W - 1){1'b0}},
                       out_rsp.pending_flag, out_rsp.result_index};

endmodule
